// ===== rtl/ssi3_pkg.sv =====
// Shared constants, types and helpers for the 3D segment intersection core.
`default_nettype none
package ssi3_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int CROSS_W        = 28;
  localparam int PARAM_W        = 20;
  localparam int LANES          = 5;

  localparam int LANE_T = 0;
  localparam int LANE_S = 1;
  localparam int LANE_X = 2;

  typedef enum logic [1:0] {
    ST_CROSS    = 2'd0,
    ST_OUTSIDE  = 2'd1,
    ST_SKEW     = 2'd2,
    ST_PARALLEL = 2'd3
  } status_t;

  function automatic int quot_bits(input int coord_bits, input int frac_bits);
    int n;
    n = coord_bits + frac_bits + 1;
    return (n > PARAM_W) ? n : PARAM_W;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ssi3_in_if.sv =====
// Request channel carrying two 3D segments.
`default_nettype none
interface ssi3_in_if #(
  parameter int COORD_BITS = ssi3_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] seg_a_start_x;
  logic signed [COORD_BITS-1:0] seg_a_start_y;
  logic signed [COORD_BITS-1:0] seg_a_start_z;
  logic signed [COORD_BITS-1:0] seg_a_end_x;
  logic signed [COORD_BITS-1:0] seg_a_end_y;
  logic signed [COORD_BITS-1:0] seg_a_end_z;
  logic signed [COORD_BITS-1:0] seg_b_start_x;
  logic signed [COORD_BITS-1:0] seg_b_start_y;
  logic signed [COORD_BITS-1:0] seg_b_start_z;
  logic signed [COORD_BITS-1:0] seg_b_end_x;
  logic signed [COORD_BITS-1:0] seg_b_end_y;
  logic signed [COORD_BITS-1:0] seg_b_end_z;

  modport source (
    output valid, seg_a_start_x, seg_a_start_y, seg_a_start_z,
           seg_a_end_x, seg_a_end_y, seg_a_end_z,
           seg_b_start_x, seg_b_start_y, seg_b_start_z,
           seg_b_end_x, seg_b_end_y, seg_b_end_z,
    input  ready
  );
  modport sink (
    input  valid, seg_a_start_x, seg_a_start_y, seg_a_start_z,
           seg_a_end_x, seg_a_end_y, seg_a_end_z,
           seg_b_start_x, seg_b_start_y, seg_b_start_z,
           seg_b_end_x, seg_b_end_y, seg_b_end_z,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/ssi3_out_if.sv =====
// Result channel carrying status, crossing point and segment parameters.
`default_nettype none
interface ssi3_out_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic signed [ssi3_pkg::CROSS_W-1:0] cross_x;
  logic signed [ssi3_pkg::CROSS_W-1:0] cross_y;
  logic signed [ssi3_pkg::CROSS_W-1:0] cross_z;
  logic signed [ssi3_pkg::PARAM_W-1:0] t_fraction;
  logic signed [ssi3_pkg::PARAM_W-1:0] s_fraction;

  modport source (
    output valid, status, cross_x, cross_y, cross_z, t_fraction, s_fraction,
    input  ready
  );
  modport sink (
    input  valid, status, cross_x, cross_y, cross_z, t_fraction, s_fraction,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/ssi3_front.sv =====
// Front pipeline: differences, dot products, determinant, numerators, status.
`default_nettype none
module ssi3_front #(
  parameter int COORD_BITS = ssi3_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = ssi3_pkg::FRAC_BITS_DEF,
  parameter int QB         = ssi3_pkg::quot_bits(ssi3_pkg::COORD_BITS_DEF,
                                                 ssi3_pkg::FRAC_BITS_DEF)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         adv,
  input  wire logic                         vld_i,
  input  wire logic signed [COORD_BITS-1:0] a_s[3],
  input  wire logic signed [COORD_BITS-1:0] a_e[3],
  input  wire logic signed [COORD_BITS-1:0] b_s[3],
  input  wire logic signed [COORD_BITS-1:0] b_e[3],
  output logic                              vld_o,
  output logic signed [2*(2*(COORD_BITS+1)+2)+QB+2:0] num_o[ssi3_pkg::LANES],
  output logic [2*(2*(COORD_BITS+1)+2):0]   den_o,
  output logic [2+3*COORD_BITS-1:0]         sb_o
);
  localparam int C    = COORD_BITS;
  localparam int DW   = C + 1;
  localparam int PW   = 2 * DW;
  localparam int SW   = 2 * DW + 2;
  localparam int CRW  = 2 * DW + 1;
  localparam int TPW  = DW + CRW;
  localparam int TRW  = TPW + 2;
  localparam int NW   = 2 * SW + 1;
  localparam int LOW  = NW / 2;
  localparam int HIW  = NW - LOW;
  localparam int PLW  = LOW + 1 + DW;
  localparam int PHW  = HIW + DW;
  localparam int NUMW = NW + QB + 2;

  logic [6:0] vld_r;

  logic signed [DW-1:0] v1_1_r[3], v2_1_r[3], w_1_r[3];
  logic signed [C-1:0]  pa_1_r[3];

  logic signed [PW-1:0] aa_2_r[3], bb_2_r[3], cc_2_r[3], dd_2_r[3], ee_2_r[3];
  logic signed [PW-1:0] cp_2_r[6];
  logic signed [DW-1:0] v1_2_r[3], w_2_r[3];
  logic signed [C-1:0]  pa_2_r[3];

  logic signed [SW-1:0]  a_3_r, b_3_r, c_3_r, d_3_r, e_3_r;
  logic signed [CRW-1:0] cr_3_r[3];
  logic signed [DW-1:0]  v1_3_r[3], w_3_r[3];
  logic signed [C-1:0]   pa_3_r[3];

  logic signed [2*SW-1:0] ac_4_r, bb_4_r, be_4_r, cd_4_r, ae_4_r, bd_4_r;
  logic signed [TPW-1:0]  tw_4_r[3];
  logic signed [DW-1:0]   v1_4_r[3];
  logic signed [C-1:0]    pa_4_r[3];

  logic signed [NW-1:0]  d_5_r, tn_5_r, sn_5_r;
  logic signed [TRW-1:0] trip_5_r;
  logic signed [DW-1:0]  v1_5_r[3];
  logic signed [C-1:0]   pa_5_r[3];

  ssi3_pkg::status_t     st_6_r;
  logic signed [PLW-1:0] tvl_6_r[3];
  logic signed [PHW-1:0] tvh_6_r[3];
  logic signed [NUMW-1:0] nt_6_r, ns_6_r;
  logic signed [NW-1:0]  d_6_r;
  logic signed [C-1:0]   pa_6_r[3];

  logic signed [NUMW-1:0] num_7_r[ssi3_pkg::LANES];
  logic [NW-1:0]          d_7_r;
  logic [2+3*C-1:0]       sb_7_r;

  ssi3_pkg::status_t st_nxt;
  logic              on_seg;

  always_comb begin
    on_seg = !tn_5_r[NW-1] && (tn_5_r <= d_5_r) && !sn_5_r[NW-1] && (sn_5_r <= d_5_r);
    if (d_5_r == '0) begin
      st_nxt = ssi3_pkg::ST_PARALLEL;
    end else if (trip_5_r != '0) begin
      st_nxt = ssi3_pkg::ST_SKEW;
    end else if (!on_seg) begin
      st_nxt = ssi3_pkg::ST_OUTSIDE;
    end else begin
      st_nxt = ssi3_pkg::ST_CROSS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[5:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        v1_1_r[k] <= DW'(a_e[k]) - DW'(a_s[k]);
        v2_1_r[k] <= DW'(b_e[k]) - DW'(b_s[k]);
        w_1_r[k]  <= DW'(a_s[k]) - DW'(b_s[k]);
        pa_1_r[k] <= a_s[k];

        aa_2_r[k] <= v1_1_r[k] * v1_1_r[k];
        bb_2_r[k] <= v1_1_r[k] * v2_1_r[k];
        cc_2_r[k] <= v2_1_r[k] * v2_1_r[k];
        dd_2_r[k] <= v1_1_r[k] * w_1_r[k];
        ee_2_r[k] <= v2_1_r[k] * w_1_r[k];
        v1_2_r[k] <= v1_1_r[k];
        w_2_r[k]  <= w_1_r[k];
        pa_2_r[k] <= pa_1_r[k];

        cr_3_r[k] <= CRW'(cp_2_r[2*k]) - CRW'(cp_2_r[2*k+1]);
        v1_3_r[k] <= v1_2_r[k];
        w_3_r[k]  <= w_2_r[k];
        pa_3_r[k] <= pa_2_r[k];

        tw_4_r[k] <= w_3_r[k] * cr_3_r[k];
        v1_4_r[k] <= v1_3_r[k];
        pa_4_r[k] <= pa_3_r[k];

        v1_5_r[k] <= v1_4_r[k];
        pa_5_r[k] <= pa_4_r[k];

        tvl_6_r[k] <= signed'({1'b0, tn_5_r[LOW-1:0]}) * v1_5_r[k];
        tvh_6_r[k] <= signed'(tn_5_r[NW-1:LOW]) * v1_5_r[k];
        pa_6_r[k]  <= pa_5_r[k];

        num_7_r[ssi3_pkg::LANE_X+k] <= (NUMW'(tvh_6_r[k]) <<< (LOW + FRAC_BITS))
                                     + (NUMW'(tvl_6_r[k]) <<< FRAC_BITS)
                                     + (NUMW'(d_6_r) <<< (QB-1));
      end
      cp_2_r[0] <= v1_1_r[1] * v2_1_r[2];
      cp_2_r[1] <= v1_1_r[2] * v2_1_r[1];
      cp_2_r[2] <= v1_1_r[2] * v2_1_r[0];
      cp_2_r[3] <= v1_1_r[0] * v2_1_r[2];
      cp_2_r[4] <= v1_1_r[0] * v2_1_r[1];
      cp_2_r[5] <= v1_1_r[1] * v2_1_r[0];

      a_3_r <= SW'(aa_2_r[0]) + SW'(aa_2_r[1]) + SW'(aa_2_r[2]);
      b_3_r <= SW'(bb_2_r[0]) + SW'(bb_2_r[1]) + SW'(bb_2_r[2]);
      c_3_r <= SW'(cc_2_r[0]) + SW'(cc_2_r[1]) + SW'(cc_2_r[2]);
      d_3_r <= SW'(dd_2_r[0]) + SW'(dd_2_r[1]) + SW'(dd_2_r[2]);
      e_3_r <= SW'(ee_2_r[0]) + SW'(ee_2_r[1]) + SW'(ee_2_r[2]);

      ac_4_r <= a_3_r * c_3_r;
      bb_4_r <= b_3_r * b_3_r;
      be_4_r <= b_3_r * e_3_r;
      cd_4_r <= c_3_r * d_3_r;
      ae_4_r <= a_3_r * e_3_r;
      bd_4_r <= b_3_r * d_3_r;

      d_5_r    <= NW'(ac_4_r) - NW'(bb_4_r);
      tn_5_r   <= NW'(be_4_r) - NW'(cd_4_r);
      sn_5_r   <= NW'(ae_4_r) - NW'(bd_4_r);
      trip_5_r <= TRW'(tw_4_r[0]) + TRW'(tw_4_r[1]) + TRW'(tw_4_r[2]);

      st_6_r <= st_nxt;
      nt_6_r <= (NUMW'(tn_5_r) <<< FRAC_BITS) + (NUMW'(d_5_r) <<< (QB-1));
      ns_6_r <= (NUMW'(sn_5_r) <<< FRAC_BITS) + (NUMW'(d_5_r) <<< (QB-1));
      d_6_r  <= d_5_r;

      num_7_r[ssi3_pkg::LANE_T] <= nt_6_r;
      num_7_r[ssi3_pkg::LANE_S] <= ns_6_r;
      d_7_r  <= d_6_r;
      sb_7_r <= {st_6_r, pa_6_r[2], pa_6_r[1], pa_6_r[0]};
    end
  end

  assign vld_o = vld_r[6];
  assign num_o = num_7_r;
  assign den_o = d_7_r;
  assign sb_o  = sb_7_r;

endmodule
`default_nettype wire

// ===== rtl/ssi3_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, shared divisor.
`default_nettype none
module ssi3_div #(
  parameter int NW    = 57,
  parameter int QB    = 29,
  parameter int LANES = ssi3_pkg::LANES,
  parameter int SBW   = 38
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     adv,
  input  wire logic                     vld_i,
  input  wire logic signed [NW+QB+1:0]  num_i[LANES],
  input  wire logic [NW-1:0]            den_i,
  input  wire logic [SBW-1:0]           sb_i,
  output logic                          vld_o,
  output logic [QB-1:0]                 q_o[LANES],
  output logic [SBW-1:0]                sb_o
);
  localparam int NUMW = NW + QB + 2;

  logic [QB:0]       vld_r;
  logic [NUMW-1:0]   rem_r[QB][LANES];
  logic [QB-1:0]     q_r[QB+1][LANES];
  logic              lo_r[QB+1][LANES];
  logic              hi_r[QB+1][LANES];
  logic [NW-1:0]     den_r[QB];
  logic [SBW-1:0]    sb_r[QB+1];
  logic [NUMW:0]     trial_w[QB][LANES];

  always_comb begin
    for (int j = 0; j < QB; j++) begin
      for (int l = 0; l < LANES; l++) begin
        trial_w[j][l] = {1'b0, rem_r[j][l]} - ((NUMW+1)'(den_r[j]) << (QB-1-j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[QB-1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_r[0] <= den_i;
      sb_r[0]  <= sb_i;
      for (int l = 0; l < LANES; l++) begin
        rem_r[0][l] <= num_i[l];
        q_r[0][l]   <= '0;
        lo_r[0][l]  <= num_i[l][NUMW-1];
        hi_r[0][l]  <= !num_i[l][NUMW-1]
                       && (num_i[l] >= (NUMW'(signed'({1'b0, den_i})) <<< QB));
      end
      for (int j = 0; j < QB; j++) begin
        sb_r[j+1] <= sb_r[j];
        for (int l = 0; l < LANES; l++) begin
          lo_r[j+1][l] <= lo_r[j][l];
          hi_r[j+1][l] <= hi_r[j][l];
          q_r[j+1][l]  <= {q_r[j][l][QB-2:0], ~trial_w[j][l][NUMW]};
        end
      end
      for (int j = 0; j < QB - 1; j++) begin
        den_r[j+1] <= den_r[j];
        for (int l = 0; l < LANES; l++) begin
          if (!trial_w[j][l][NUMW]) begin
            rem_r[j+1][l] <= trial_w[j][l][NUMW-1:0];
          end else begin
            rem_r[j+1][l] <= rem_r[j][l];
          end
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (lo_r[QB][l]) begin
        q_o[l] = '0;
      end else if (hi_r[QB][l]) begin
        q_o[l] = '1;
      end else begin
        q_o[l] = q_r[QB][l];
      end
    end
  end

  assign vld_o = vld_r[QB];
  assign sb_o  = sb_r[QB];

endmodule
`default_nettype wire

// ===== rtl/ssi3_back.sv =====
// Output stage: unbias quotients, form crossing point, saturate, mask by status.
`default_nettype none
module ssi3_back #(
  parameter int COORD_BITS = ssi3_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = ssi3_pkg::FRAC_BITS_DEF,
  parameter int QB         = ssi3_pkg::quot_bits(ssi3_pkg::COORD_BITS_DEF,
                                                 ssi3_pkg::FRAC_BITS_DEF)
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               adv,
  input  wire logic                               vld_i,
  input  wire logic [QB-1:0]                      q_i[ssi3_pkg::LANES],
  input  wire logic [2+3*COORD_BITS-1:0]          sb_i,
  output logic                                    vld_o,
  output logic [1:0]                              status_o,
  output logic signed [ssi3_pkg::CROSS_W-1:0]     cross_o[3],
  output logic signed [ssi3_pkg::PARAM_W-1:0]     t_o,
  output logic signed [ssi3_pkg::PARAM_W-1:0]     s_o
);
  localparam int C   = COORD_BITS;
  localparam int SBW = 2 + 3 * C;
  localparam int TW  = QB + 1;
  localparam int XW  = ((QB + 2 > ssi3_pkg::CROSS_W) ? QB + 2 : ssi3_pkg::CROSS_W) + 1;
  localparam int PWO = ssi3_pkg::PARAM_W;
  localparam int CWO = ssi3_pkg::CROSS_W;

  localparam logic signed [TW-1:0] BIAS = {2'b01, {(QB-1){1'b0}}};
  localparam logic signed [TW-1:0] TMAX = TW'((64'sd1 <<< (PWO-1)) - 64'sd1);
  localparam logic signed [TW-1:0] TMIN = TW'(-(64'sd1 <<< (PWO-1)));
  localparam logic signed [XW-1:0] XMAX = XW'((64'sd1 <<< (CWO-1)) - 64'sd1);
  localparam logic signed [XW-1:0] XMIN = XW'(-(64'sd1 <<< (CWO-1)));

  ssi3_pkg::status_t       st_w;
  logic signed [TW-1:0]    qs_w[ssi3_pkg::LANES];
  logic signed [C-1:0]     pa_w[3];
  logic signed [XW-1:0]    xs_w[3];
  logic signed [PWO-1:0]   t_sat, s_sat;
  logic signed [CWO-1:0]   x_sat[3];

  logic                    vld_r;
  logic [1:0]              status_r;
  logic signed [CWO-1:0]   cross_r[3];
  logic signed [PWO-1:0]   t_r, s_r;

  function automatic logic signed [PWO-1:0] sat_p(input logic signed [TW-1:0] v);
    if (v > TMAX) begin
      return PWO'(TMAX);
    end else if (v < TMIN) begin
      return PWO'(TMIN);
    end
    return PWO'(v);
  endfunction

  function automatic logic signed [CWO-1:0] sat_x(input logic signed [XW-1:0] v);
    if (v > XMAX) begin
      return CWO'(XMAX);
    end else if (v < XMIN) begin
      return CWO'(XMIN);
    end
    return CWO'(v);
  endfunction

  always_comb begin
    st_w = ssi3_pkg::status_t'(sb_i[SBW-1 -: 2]);
    for (int l = 0; l < ssi3_pkg::LANES; l++) begin
      qs_w[l] = signed'({1'b0, q_i[l]}) - BIAS;
    end
    for (int k = 0; k < 3; k++) begin
      pa_w[k]  = sb_i[k*C +: C];
      xs_w[k]  = (XW'(pa_w[k]) <<< FRAC_BITS) + XW'(qs_w[ssi3_pkg::LANE_X+k]);
      x_sat[k] = sat_x(xs_w[k]);
    end
    t_sat = sat_p(qs_w[ssi3_pkg::LANE_T]);
    s_sat = sat_p(qs_w[ssi3_pkg::LANE_S]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= st_w;
      if (st_w == ssi3_pkg::ST_PARALLEL) begin
        t_r <= '0;
        s_r <= '0;
      end else begin
        t_r <= t_sat;
        s_r <= s_sat;
      end
      for (int k = 0; k < 3; k++) begin
        cross_r[k] <= (st_w == ssi3_pkg::ST_CROSS) ? x_sat[k] : '0;
      end
    end
  end

  assign vld_o    = vld_r;
  assign status_o = status_r;
  assign cross_o  = cross_r;
  assign t_o      = t_r;
  assign s_o      = s_r;

endmodule
`default_nettype wire

// ===== rtl/segment_segment_intersect_3d_core.sv =====
// Pipeline: seven arithmetic stages, one divider setup stage, one divider stage per
//   quotient bit, one output register.
// Throughput: one request per cycle; a stalled result holds the whole pipeline in place.
// Reset: synchronous, active low; clears the stage valid bits only.
`default_nettype none
module segment_segment_intersect_3d_core #(
  parameter int COORD_BITS = ssi3_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = ssi3_pkg::FRAC_BITS_DEF
) (
  input wire logic     clk,
  input wire logic     rst_n,
  ssi3_in_if.sink      in_ch,
  ssi3_out_if.source   out_ch
);
  localparam int C    = COORD_BITS;
  localparam int DW   = C + 1;
  localparam int SW   = 2 * DW + 2;
  localparam int NW   = 2 * SW + 1;
  localparam int QB   = ssi3_pkg::quot_bits(COORD_BITS, FRAC_BITS);
  localparam int NUMW = NW + QB + 2;
  localparam int SBW  = 2 + 3 * C;

  logic adv;
  logic out_vld;

  logic signed [C-1:0] a_s[3], a_e[3], b_s[3], b_e[3];

  logic                   f_vld;
  logic signed [NUMW-1:0] f_num[ssi3_pkg::LANES];
  logic [NW-1:0]          f_den;
  logic [SBW-1:0]         f_sb;

  logic                   d_vld;
  logic [QB-1:0]          d_q[ssi3_pkg::LANES];
  logic [SBW-1:0]         d_sb;

  logic signed [ssi3_pkg::CROSS_W-1:0] cross_w[3];

  assign adv         = !out_vld || out_ch.ready;
  assign in_ch.ready = adv;

  assign a_s[0] = in_ch.seg_a_start_x;
  assign a_s[1] = in_ch.seg_a_start_y;
  assign a_s[2] = in_ch.seg_a_start_z;
  assign a_e[0] = in_ch.seg_a_end_x;
  assign a_e[1] = in_ch.seg_a_end_y;
  assign a_e[2] = in_ch.seg_a_end_z;
  assign b_s[0] = in_ch.seg_b_start_x;
  assign b_s[1] = in_ch.seg_b_start_y;
  assign b_s[2] = in_ch.seg_b_start_z;
  assign b_e[0] = in_ch.seg_b_end_x;
  assign b_e[1] = in_ch.seg_b_end_y;
  assign b_e[2] = in_ch.seg_b_end_z;

  ssi3_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .QB         (QB)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .vld_i (in_ch.valid),
    .a_s   (a_s),
    .a_e   (a_e),
    .b_s   (b_s),
    .b_e   (b_e),
    .vld_o (f_vld),
    .num_o (f_num),
    .den_o (f_den),
    .sb_o  (f_sb)
  );

  ssi3_div #(
    .NW    (NW),
    .QB    (QB),
    .LANES (ssi3_pkg::LANES),
    .SBW   (SBW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .vld_i (f_vld),
    .num_i (f_num),
    .den_i (f_den),
    .sb_i  (f_sb),
    .vld_o (d_vld),
    .q_o   (d_q),
    .sb_o  (d_sb)
  );

  ssi3_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .QB         (QB)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .vld_i    (d_vld),
    .q_i      (d_q),
    .sb_i     (d_sb),
    .vld_o    (out_vld),
    .status_o (out_ch.status),
    .cross_o  (cross_w),
    .t_o      (out_ch.t_fraction),
    .s_o      (out_ch.s_fraction)
  );

  assign out_ch.valid   = out_vld;
  assign out_ch.cross_x = cross_w[0];
  assign out_ch.cross_y = cross_w[1];
  assign out_ch.cross_z = cross_w[2];

endmodule
`default_nettype wire
